// ===== hdl/ssim_pkg.sv =====
// shared types, constants and helpers for the sorted signed id membership core
package ssim_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int USER_W      = 31;
  localparam int OP_W        = 2;
  localparam int COUNT_OUT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    key_t              wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } ram_cmd_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  typedef struct packed {
    logic                   found;
    logic                   status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

  function automatic key_t make_key(input logic [USER_W-1:0] user, input logic bad);
    key_t mag;
    mag = key_t'({1'b0, user});
    return bad ? key_t'(0 - mag) : mag;
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+COUNT_OUT_W-1:0] ext;
    ext = {{COUNT_OUT_W{1'b0}}, cnt};
    return ext[COUNT_OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/ssim_key_ram.sv =====
// key table memory, one write port and one registered read port
module ssim_key_ram (
  input  logic                clk,
  input  ssim_pkg::ram_cmd_t  cmd,
  output ssim_pkg::key_t      rd_data
);
  import ssim_pkg::*;

  key_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_data <= mem[cmd.rd_addr];
  end

endmodule

// ===== hdl/ssim_cmp.sv =====
// shared signed key comparator
module ssim_cmp (
  input  ssim_pkg::key_t  probe,
  input  ssim_pkg::key_t  key,
  output ssim_pkg::cmp_t  res
);
  import ssim_pkg::*;

  always_comb begin
    res.eq = (probe == key);
    res.gt = (probe > key);
  end

endmodule

// ===== hdl/ssim_seq.sv =====
// sequencer for clear, insert with shift, and binary search query
module ssim_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssim_pkg::OP_W-1:0]   start_op,
  input  ssim_pkg::key_t              start_key,
  output logic                        idle,
  input  ssim_pkg::key_t              rd_data,
  input  ssim_pkg::cmp_t              cmp,
  output ssim_pkg::key_t              cmp_key,
  output ssim_pkg::ram_cmd_t          ram_cmd,
  output logic                        res_valid,
  input  logic                        res_take,
  output ssim_pkg::res_t              res
);
  import ssim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_CHK, S_SH_RD, S_SH_WR, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  key_t             key_r, key_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             found_r, found_nxt;
  logic             status_r, status_nxt;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] lo_m1;
  logic [CNT_W-1:0] j_m1;

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1 = lo_r - CNT_W'(1);
  assign j_m1  = j_r - CNT_W'(1);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign cmp_key   = key_r;
  assign res.found       = found_r;
  assign res.status      = status_r;
  assign res.entry_count = count_out(cnt_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ram_cmd.wr_en   = 1'b0;
    ram_cmd.wr_addr = lo_r[ADDR_W-1:0];
    ram_cmd.wr_data = key_r;
    ram_cmd.rd_addr = mid[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = op_t'(start_op);
          key_nxt    = start_key;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          state_nxt  = S_DONE;
          case (start_op)
            OP_CLEAR: cnt_nxt = '0;
            OP_INSERT: begin
              if (cnt_r >= CNT_W'(TABLE_DEPTH)) status_nxt = 1'b1;
              else state_nxt = S_RD;
            end
            OP_QUERY: state_nxt = S_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_CMP;
        end else if (op_r == OP_INSERT) begin
          j_nxt     = cnt_r;
          state_nxt = S_SH_RD;
        end else if (lo_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          ram_cmd.rd_addr = lo_m1[ADDR_W-1:0];
          state_nxt       = S_CHK;
        end
      end
      S_CMP: begin
        if (cmp.gt) hi_nxt = mid;
        else lo_nxt = mid + CNT_W'(1);
        state_nxt = S_RD;
      end
      S_CHK: begin
        found_nxt = cmp.eq;
        state_nxt = S_DONE;
      end
      S_SH_RD: begin
        if (j_r > lo_r) begin
          ram_cmd.rd_addr = j_m1[ADDR_W-1:0];
          state_nxt       = S_SH_WR;
        end else begin
          ram_cmd.wr_en = 1'b1;
          cnt_nxt       = cnt_r + CNT_W'(1);
          state_nxt     = S_DONE;
        end
      end
      S_SH_WR: begin
        ram_cmd.wr_en   = 1'b1;
        ram_cmd.wr_addr = j_r[ADDR_W-1:0];
        ram_cmd.wr_data = rd_data;
        j_nxt           = j_m1;
        state_nxt       = S_SH_RD;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    j_r      <= j_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== hdl/sorted_signed_id_membership_core.sv =====
// Sorted table of signed user keys (+user good, -user bad) with clear, insert and query.
// One word is processed at a time; in_ready is low while it runs. Clear and unused op
// codes go straight to the result. A query runs a binary search on the shared comparator,
// each probe being a memory read, then a compare. An insert runs the same search, then
// moves each larger key up by one slot, reading it and writing it back through the
// memory's read and write ports. A refused insert on a full table skips the search.
// Results sit in an output register, so the next word can be taken while a result waits.
module sorted_signed_id_membership_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssim_pkg::OP_W-1:0]     in_op,
  input  logic [ssim_pkg::USER_W-1:0]   in_user_number,
  input  logic                          in_bad_mark,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic                          out_status,
  output logic [ssim_pkg::COUNT_OUT_W-1:0] out_entry_count
);
  import ssim_pkg::*;

  logic     seq_idle;
  logic     res_valid;
  logic     res_take;
  res_t     res;
  key_t     rd_data;
  key_t     cmp_key;
  cmp_t     cmp;
  ram_cmd_t ram_cmd;
  logic     out_valid_r;
  res_t     out_r;

  assign in_ready = seq_idle;
  assign res_take = !out_valid_r || out_ready;

  ssim_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .start_op  (in_op),
    .start_key (make_key(in_user_number, in_bad_mark)),
    .idle      (seq_idle),
    .rd_data   (rd_data),
    .cmp       (cmp),
    .cmp_key   (cmp_key),
    .ram_cmd   (ram_cmd),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  ssim_key_ram u_ram (
    .clk     (clk),
    .cmd     (ram_cmd),
    .rd_data (rd_data)
  );

  ssim_cmp u_cmp (
    .probe (rd_data),
    .key   (cmp_key),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_r.found;
  assign out_status      = out_r.status;
  assign out_entry_count = out_r.entry_count;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core still ready after taking a word");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid)
    else $error("finished result not loaded into output register");

  a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found)
    else $error("refused insert reports found");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TABLE_DEPTH > 255) || (out_entry_count <= COUNT_OUT_W'(TABLE_DEPTH)))
    else $error("entry count above table depth");

endmodule
